// File: rtl/lfps_pkg.sv
// Shared widths, codes and types for the line follower PID steering block.
`timescale 1ns / 1ps
`default_nettype none

package lfps_pkg;

    // Basic field widths.
    localparam int SUM_BITS       = 16;
    localparam int GAIN_FRAC_BITS = 4;
    localparam int SPEED_BITS     = 8;
    localparam int GAIN_BITS      = 12;
    localparam int ERR_BITS       = 3;
    localparam int DELTA_BITS     = ERR_BITS + 1;

    // Configuration port.
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = (GAIN_BITS > SPEED_BITS) ? GAIN_BITS : SPEED_BITS;

    localparam logic [CFG_INDEX_BITS-1:0] REG_PROP_GAIN      = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_INTEG_GAIN     = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DERIV_GAIN     = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BASE_SPEED_ONE = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BASE_SPEED_TWO = 3'd4;

    localparam logic [GAIN_BITS-1:0]  PROP_GAIN_RESET  = 12'd176;
    localparam logic [GAIN_BITS-1:0]  INTEG_GAIN_RESET = 12'd0;
    localparam logic [GAIN_BITS-1:0]  DERIV_GAIN_RESET = 12'd176;
    localparam logic [SPEED_BITS-1:0] BASE_SPEED_RESET = SPEED_BITS'(40);

    // Top of the motor speed range.
    localparam logic [SPEED_BITS-1:0] SPEED_MAX = {SPEED_BITS{1'b1}};

    // Limits of the saturating integral.
    localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
    localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

    // Sensor patterns, bits ordered a b c.
    localparam logic [2:0] PAT_NONE     = 3'b000;
    localparam logic [2:0] PAT_NEG_ONE  = 3'b001;
    localparam logic [2:0] PAT_MIDDLE   = 3'b010;
    localparam logic [2:0] PAT_NEG_TWO  = 3'b011;
    localparam logic [2:0] PAT_POS_ONE  = 3'b100;
    localparam logic [2:0] PAT_OUTER    = 3'b101;
    localparam logic [2:0] PAT_POS_TWO  = 3'b110;
    localparam logic [2:0] PAT_ALL      = 3'b111;

    // Line error values.
    localparam logic signed [ERR_BITS-1:0] ERR_NEG_THREE = -3'sd3;
    localparam logic signed [ERR_BITS-1:0] ERR_NEG_TWO   = -3'sd2;
    localparam logic signed [ERR_BITS-1:0] ERR_NEG_ONE   = -3'sd1;
    localparam logic signed [ERR_BITS-1:0] ERR_ZERO      = 3'sd0;
    localparam logic signed [ERR_BITS-1:0] ERR_POS_ONE   = 3'sd1;
    localparam logic signed [ERR_BITS-1:0] ERR_POS_TWO   = 3'sd2;
    localparam logic signed [ERR_BITS-1:0] ERR_POS_THREE = 3'sd3;

    // Datapath widths of the PID terms.
    localparam int PROP_BITS   = GAIN_BITS + 1 + ERR_BITS;
    localparam int INTEG_BITS  = GAIN_BITS + 1 + SUM_BITS;
    localparam int DERIV_BITS  = GAIN_BITS + 1 + DELTA_BITS;
    localparam int ACC_BITS    = INTEG_BITS + 2;
    localparam int DRIVE_BITS  = ACC_BITS - GAIN_FRAC_BITS;
    localparam int SPD_CALC_BITS =
        ((DRIVE_BITS > SPEED_BITS + 1) ? DRIVE_BITS : SPEED_BITS + 1) + 1;

    // Configuration register set.
    typedef struct packed {
        logic [GAIN_BITS-1:0]  prop_gain;
        logic [GAIN_BITS-1:0]  integ_gain;
        logic [GAIN_BITS-1:0]  deriv_gain;
        logic [SPEED_BITS-1:0] base_speed_one;
        logic [SPEED_BITS-1:0] base_speed_two;
    } lfps_cfg_t;

    // Error stage output: error, updated integral and error difference.
    typedef struct packed {
        logic signed [ERR_BITS-1:0]   err;
        logic signed [SUM_BITS-1:0]   sum;
        logic signed [DELTA_BITS-1:0] delta;
    } lfps_err_t;

endpackage

`default_nettype wire

// File: rtl/lfps_error.sv
// Sensor pattern decoder with last error and saturating integral state.
`timescale 1ns / 1ps
`default_nettype none

module lfps_error (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              sensor_a,
    input  wire logic              sensor_b,
    input  wire logic              sensor_c,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output lfps_pkg::lfps_err_t    out_data
);
    import lfps_pkg::*;

    logic signed [ERR_BITS-1:0] last_error_reg;
    logic signed [SUM_BITS-1:0] error_sum_reg;
    logic                       st_valid_reg;
    lfps_err_t                  st_data_reg;

    logic [2:0]                 pattern;
    logic signed [ERR_BITS-1:0] err_next;
    logic signed [SUM_BITS:0]   sum_wide;
    logic signed [SUM_BITS-1:0] sum_next;
    logic signed [DELTA_BITS-1:0] delta_next;
    logic                       accept;

    assign in_ready  = !st_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = st_valid_reg;
    assign out_data  = st_data_reg;

    // Map the sensor pattern to a line error.
    assign pattern = {sensor_a, sensor_b, sensor_c};

    always_comb begin
        unique case (pattern)
            PAT_POS_TWO: err_next = ERR_POS_TWO;
            PAT_POS_ONE: err_next = ERR_POS_ONE;
            PAT_OUTER:   err_next = ERR_ZERO;
            PAT_NEG_ONE: err_next = ERR_NEG_ONE;
            PAT_NEG_TWO: err_next = ERR_NEG_TWO;
            PAT_ALL:     err_next = (last_error_reg == ERR_NEG_TWO) ? ERR_NEG_THREE
                                                                    : ERR_POS_THREE;
            PAT_NONE:    err_next = ERR_ZERO;
            PAT_MIDDLE:  err_next = last_error_reg;
        endcase
    end

    // Saturating integral update: overflow shows as a mismatch of the top two bits.
    always_comb begin
        sum_wide = {error_sum_reg[SUM_BITS-1], error_sum_reg}
                 + {{(SUM_BITS+1-ERR_BITS){err_next[ERR_BITS-1]}}, err_next};
        if (sum_wide[SUM_BITS] != sum_wide[SUM_BITS-1]) begin
            sum_next = sum_wide[SUM_BITS] ? SUM_MIN : SUM_MAX;
        end else begin
            sum_next = sum_wide[SUM_BITS-1:0];
        end
    end

    // Difference to the previous error for the derivative term.
    assign delta_next = {err_next[ERR_BITS-1], err_next}
                      - {last_error_reg[ERR_BITS-1], last_error_reg};

    // Controller state follows every accepted transaction.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_error_reg <= ERR_ZERO;
            error_sum_reg  <= '0;
        end else if (accept) begin
            last_error_reg <= err_next;
            error_sum_reg  <= sum_next;
        end
    end

    // Output register of this stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= 1'b0;
        end else if (in_ready) begin
            st_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st_data_reg.err   <= err_next;
            st_data_reg.sum   <= sum_next;
            st_data_reg.delta <= delta_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/lfps_pid.sv
// PID products, drive value and saturated motor speeds computed in one pass into the result register.
`timescale 1ns / 1ps
`default_nettype none

module lfps_pid (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire lfps_pkg::lfps_cfg_t                  cfg,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire lfps_pkg::lfps_err_t                  in_data,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic [lfps_pkg::SPEED_BITS-1:0]           speed_one,
    output logic [lfps_pkg::SPEED_BITS-1:0]           speed_two,
    output logic signed [lfps_pkg::ERR_BITS-1:0]      line_error,
    output logic                                      clipped
);
    import lfps_pkg::*;

    // Result stage.
    logic                          o_valid_reg;
    logic [SPEED_BITS-1:0]         speed_one_reg;
    logic [SPEED_BITS-1:0]         speed_two_reg;
    logic signed [ERR_BITS-1:0]    o_err_reg;
    logic                          clipped_reg;

    logic signed [PROP_BITS-1:0]   prop_next;
    logic signed [INTEG_BITS-1:0]  integ_next;
    logic signed [DERIV_BITS-1:0]  deriv_next;
    logic signed [ACC_BITS-1:0]    acc;
    logic signed [DRIVE_BITS-1:0]  drive;
    logic signed [SPD_CALC_BITS-1:0] base_one_ext;
    logic signed [SPD_CALC_BITS-1:0] base_two_ext;
    logic signed [SPD_CALC_BITS-1:0] drive_ext;
    logic signed [SPD_CALC_BITS-1:0] raw_one;
    logic signed [SPD_CALC_BITS-1:0] raw_two;
    logic [SPEED_BITS-1:0]         sat_one;
    logic [SPEED_BITS-1:0]         sat_two;
    logic                          clip_one;
    logic                          clip_two;

    // The result register takes a new transaction when empty or when its content moves on.
    assign in_ready = !o_valid_reg || out_ready;

    // Gain products, operands extended to the full product width.
    assign prop_next =
        $signed({{(PROP_BITS-GAIN_BITS){1'b0}}, cfg.prop_gain})
      * $signed({{(PROP_BITS-ERR_BITS){in_data.err[ERR_BITS-1]}}, in_data.err});
    assign integ_next =
        $signed({{(INTEG_BITS-GAIN_BITS){1'b0}}, cfg.integ_gain})
      * $signed({{(INTEG_BITS-SUM_BITS){in_data.sum[SUM_BITS-1]}}, in_data.sum});
    assign deriv_next =
        $signed({{(DERIV_BITS-GAIN_BITS){1'b0}}, cfg.deriv_gain})
      * $signed({{(DERIV_BITS-DELTA_BITS){in_data.delta[DELTA_BITS-1]}}, in_data.delta});

    // Sum of the terms; dropping the fraction bits rounds towards minus infinity.
    assign acc = {{(ACC_BITS-PROP_BITS){prop_next[PROP_BITS-1]}}, prop_next}
               + {{(ACC_BITS-INTEG_BITS){integ_next[INTEG_BITS-1]}}, integ_next}
               + {{(ACC_BITS-DERIV_BITS){deriv_next[DERIV_BITS-1]}}, deriv_next};
    assign drive = acc[ACC_BITS-1:GAIN_FRAC_BITS];

    // Motor speeds before saturation.
    assign base_one_ext = $signed({{(SPD_CALC_BITS-SPEED_BITS){1'b0}}, cfg.base_speed_one});
    assign base_two_ext = $signed({{(SPD_CALC_BITS-SPEED_BITS){1'b0}}, cfg.base_speed_two});
    assign drive_ext    = {{(SPD_CALC_BITS-DRIVE_BITS){drive[DRIVE_BITS-1]}}, drive};
    assign raw_two      = base_two_ext + drive_ext;
    assign raw_one      = base_one_ext - drive_ext;

    // Clamp each speed to the motor range and flag any clamping.
    always_comb begin
        clip_one = 1'b0;
        sat_one  = raw_one[SPEED_BITS-1:0];
        if (raw_one[SPD_CALC_BITS-1]) begin
            clip_one = 1'b1;
            sat_one  = '0;
        end else if (|raw_one[SPD_CALC_BITS-2:SPEED_BITS]) begin
            clip_one = 1'b1;
            sat_one  = SPEED_MAX;
        end
    end

    always_comb begin
        clip_two = 1'b0;
        sat_two  = raw_two[SPEED_BITS-1:0];
        if (raw_two[SPD_CALC_BITS-1]) begin
            clip_two = 1'b1;
            sat_two  = '0;
        end else if (|raw_two[SPD_CALC_BITS-2:SPEED_BITS]) begin
            clip_two = 1'b1;
            sat_two  = SPEED_MAX;
        end
    end

    // Result register, held while the consumer stalls.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg <= 1'b0;
        end else if (in_ready) begin
            o_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            speed_one_reg <= sat_one;
            speed_two_reg <= sat_two;
            o_err_reg     <= in_data.err;
            clipped_reg   <= clip_one || clip_two;
        end
    end

    assign out_valid  = o_valid_reg;
    assign speed_one  = speed_one_reg;
    assign speed_two  = speed_two_reg;
    assign line_error = o_err_reg;
    assign clipped    = clipped_reg;

endmodule

`default_nettype wire

// File: rtl/line_follower_pid_steering_top.sv
// An accepted input transaction is held in the error stage register and then in the
// result register, from which it is presented; a stall on the result side can keep it waiting.
// Throughput: one transaction per cycle through two registers (error decode with
// the controller state, then products, drive and saturated speeds); only a stall on
// the result side holds the input back.
// Reset: synchronous, active low; clears the last error, the integral and all
// valid flags, and loads the gains and base speeds with their default values.
`timescale 1ns / 1ps
`default_nettype none

module line_follower_pid_steering_top (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // Configuration write channel.
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [lfps_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  wire logic [lfps_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    // Sensor sample channel.
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic                                  s_sensor_a,
    input  wire logic                                  s_sensor_b,
    input  wire logic                                  s_sensor_c,
    // Steering result channel.
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic [lfps_pkg::SPEED_BITS-1:0]            m_speed_one,
    output logic [lfps_pkg::SPEED_BITS-1:0]            m_speed_two,
    output logic signed [lfps_pkg::ERR_BITS-1:0]       m_line_error,
    output logic                                       m_clipped
);
    import lfps_pkg::*;

    lfps_cfg_t cfg_reg;
    logic      err_valid;
    logic      err_ready;
    lfps_err_t err_data;

    // Register writes are always taken.
    assign cfg_ready = 1'b1;

    // Configuration registers; an index beyond the list is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.prop_gain      <= PROP_GAIN_RESET;
            cfg_reg.integ_gain     <= INTEG_GAIN_RESET;
            cfg_reg.deriv_gain     <= DERIV_GAIN_RESET;
            cfg_reg.base_speed_one <= BASE_SPEED_RESET;
            cfg_reg.base_speed_two <= BASE_SPEED_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_PROP_GAIN:      cfg_reg.prop_gain      <= cfg_data[GAIN_BITS-1:0];
                REG_INTEG_GAIN:     cfg_reg.integ_gain     <= cfg_data[GAIN_BITS-1:0];
                REG_DERIV_GAIN:     cfg_reg.deriv_gain     <= cfg_data[GAIN_BITS-1:0];
                REG_BASE_SPEED_ONE: cfg_reg.base_speed_one <= cfg_data[SPEED_BITS-1:0];
                REG_BASE_SPEED_TWO: cfg_reg.base_speed_two <= cfg_data[SPEED_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Error decode and controller state.
    lfps_error u_error (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .sensor_a  (s_sensor_a),
        .sensor_b  (s_sensor_b),
        .sensor_c  (s_sensor_c),
        .out_valid (err_valid),
        .out_ready (err_ready),
        .out_data  (err_data)
    );

    // PID law and speed saturation.
    lfps_pid u_pid (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_valid   (err_valid),
        .in_ready   (err_ready),
        .in_data    (err_data),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .speed_one  (m_speed_one),
        .speed_two  (m_speed_two),
        .line_error (m_line_error),
        .clipped    (m_clipped)
    );

    // No result may be presented in the cycle after reset.
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid straight after reset");

    // The line error never takes the one code outside -3 .. 3.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_line_error != 3'b100))
        else $error("line error out of range");

    // A clipped result must show at least one speed at a rail.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_clipped) |->
            (m_speed_one == '0 || m_speed_one == SPEED_MAX ||
             m_speed_two == '0 || m_speed_two == SPEED_MAX))
        else $error("clip flag set with both speeds inside the range");

    // With the result side free, the pipeline must be able to take a sample.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid || m_ready) |-> s_ready)
        else $error("input stalled although the result side is free");

endmodule

`default_nettype wire
